// File: rtl/radix2_fft_in_place_defines.svh
// assertion macros for the fft block
`ifndef RADIX2_FFT_IN_PLACE_DEFINES_SVH
`define RADIX2_FFT_IN_PLACE_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFT_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("fft assertion failed");
`define FFT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fft assertion failed");
`else
`define FFT_ASSERT(lbl, expr)
`define FFT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/fft_pkg.sv
package fft_pkg;

    localparam int POINTS  = 512;
    localparam int LOG2    = $clog2(POINTS);
    localparam int QUARTER = POINTS / 4;
    localparam int STG_W   = $clog2(LOG2);
    localparam int IDX_W   = 9;
    localparam int SMP_W   = 16;
    localparam int BIN_W   = 25;
    localparam int PROD_W  = BIN_W + SMP_W;
    localparam int T_W     = PROD_W + 1 - 15;
    localparam int SUM_W   = T_W + 1;
    localparam real PI     = 3.1415926535897932384626433832795;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] MUL_RR = 2'd0;
    localparam logic [1:0] MUL_II = 2'd1;
    localparam logic [1:0] MUL_RI = 2'd2;
    localparam logic [1:0] MUL_IR = 2'd3;

    typedef logic signed [SMP_W-1:0] t_qsin [0:QUARTER];

    typedef struct packed {
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_ld;
        logic       tr_ld;
        logic       ti_ld;
    } t_bf_ctl;

    // quarter-wave sine in q1.15, full scale clamped to 32767
    function automatic t_qsin f_qsin();
        t_qsin  tab;
        real    v;
        integer r;
        for (int m = 0; m <= QUARTER; m++) begin
            v = 32768.0 * $sin(PI / 2.0 * m / QUARTER);
            r = $rtoi(v + 0.5);
            if (r > 32767) r = 32767;
            tab[m] = SMP_W'(r);
        end
        return tab;
    endfunction

    localparam t_qsin QSIN = f_qsin();

    function automatic logic signed [BIN_W-1:0] f_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(16777215);
        lo = -SUM_W'(16777216);
        if (v > hi) return BIN_W'(hi);
        if (v < lo) return BIN_W'(lo);
        return v[BIN_W-1:0];
    endfunction

endpackage

// File: rtl/radix2_fft_in_place.sv
// In-place radix-2 decimation-in-time fft over a 512-point complex store
// (25-bit real and imaginary words). Each item is a write, start or read
// request, or any other type code, and gives exactly one result; only a
// read returns nonzero data. A start first bit-reverses the store, checking
// each index and swapping each pair with two reads and two writes, then runs
// 9 stages of 256 butterflies; each butterfly reads its two operands, forms
// the four twiddle products in turn on the one shared 25x16 multiplier and
// writes its two results back. The block takes no new item while a
// transform runs. Bins read before any write are undefined.
`include "radix2_fft_in_place_defines.svh"

module radix2_fft_in_place (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_req_type,
    input  logic [fft_pkg::IDX_W-1:0]           i_point_index,
    input  logic signed [fft_pkg::SMP_W-1:0]    i_sample_real,
    input  logic signed [fft_pkg::SMP_W-1:0]    i_sample_imag,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [fft_pkg::BIN_W-1:0]    o_bin_real,
    output logic signed [fft_pkg::BIN_W-1:0]    o_bin_imag
);
    import fft_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_RDOUT = 16'h0002,
        S_SW0   = 16'h0004,
        S_SW1   = 16'h0008,
        S_SW2   = 16'h0010,
        S_SW3   = 16'h0020,
        S_B0    = 16'h0040,
        S_B1    = 16'h0080,
        S_M0    = 16'h0100,
        S_M1    = 16'h0200,
        S_M2    = 16'h0400,
        S_M3    = 16'h0800,
        S_M4    = 16'h1000,
        S_WA    = 16'h2000,
        S_WB    = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    t_state r_state, n_state;

    logic [2*BIN_W-1:0] r_mem [POINTS];
    logic [2*BIN_W-1:0] r_rdata;
    logic [2*BIN_W-1:0] r_hold;
    logic [LOG2-1:0]    raddr;
    logic [LOG2-1:0]    waddr;
    logic [2*BIN_W-1:0] wdata;
    logic               we;

    logic [LOG2-1:0]  r_cnt, n_cnt;
    logic [STG_W-1:0] r_stage, n_stage;
    logic [LOG2-1:0]  r_idx, n_idx;
    logic             r_rd_ok, n_rd_ok;
    logic             r_ovalid, n_ovalid;
    logic signed [BIN_W-1:0] r_ore, n_ore, r_oim, n_oim;

    logic signed [BIN_W-1:0] r_x_re, r_x_im, r_a_re, r_a_im;
    logic signed [SMP_W-1:0] r_w_re, r_w_im;
    logic signed [SMP_W-1:0] w_re, w_im;

    logic            accept;
    logic            in_range;
    logic            out_free;
    logic [LOG2-1:0] rev;
    logic [LOG2-2:0] bidx;
    logic [LOG2-1:0] half_v, jv, grp, i_a, i_b, k_full;
    logic [LOG2-2:0] kk;
    logic [STG_W-1:0] tw_sh;
    logic            last_bfly, last_stage;
    t_bf_ctl         bf_ctl;
    logic signed [BIN_W-1:0] sum_re, sum_im, dif_re, dif_im;

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign in_range = 32'(i_point_index) < POINTS;

    always_comb begin
        for (int b = 0; b < LOG2; b++) rev[b] = r_cnt[LOG2-1-b];
    end

    // butterfly addressing for index bidx in stage r_stage
    assign bidx       = r_cnt[LOG2-2:0];
    assign half_v     = LOG2'(1) << r_stage;
    assign jv         = {1'b0, bidx} & (half_v - LOG2'(1));
    assign grp        = (({1'b0, bidx} >> r_stage) << r_stage) << 1;
    assign i_a        = grp | jv;
    assign i_b        = i_a | half_v;
    assign tw_sh      = STG_W'(LOG2 - 1) - r_stage;
    assign k_full     = jv << tw_sh;
    assign kk         = k_full[LOG2-2:0];
    assign last_bfly  = &bidx;
    assign last_stage = (r_stage == STG_W'(LOG2 - 1));

    always_comb begin
        if (kk <= (LOG2-1)'(QUARTER)) begin
            w_re = QSIN[(LOG2-1)'(QUARTER) - kk];
            w_im = -QSIN[kk];
        end else begin
            w_re = -QSIN[kk - (LOG2-1)'(QUARTER)];
            w_im = -QSIN[(LOG2-1)'(2 * QUARTER) - kk];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_stage  = r_stage;
        n_idx    = r_idx;
        n_rd_ok  = r_rd_ok;
        n_ovalid = r_ovalid && !i_ready;
        n_ore    = r_ore;
        n_oim    = r_oim;
        raddr    = r_idx;
        waddr    = r_cnt;
        wdata    = r_rdata;
        we       = 1'b0;
        bf_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                raddr = LOG2'(i_point_index);
                if (accept) begin
                    unique case (i_req_type)
                        REQ_WRITE: begin
                            we       = in_range;
                            waddr    = LOG2'(i_point_index);
                            wdata    = {BIN_W'(i_sample_real), BIN_W'(i_sample_imag)};
                            n_ovalid = 1'b1;
                            n_ore    = '0;
                            n_oim    = '0;
                        end
                        REQ_START: begin
                            n_cnt   = '0;
                            n_stage = '0;
                            n_state = S_SW0;
                        end
                        REQ_READ: begin
                            n_idx   = LOG2'(i_point_index);
                            n_rd_ok = in_range;
                            n_state = S_RDOUT;
                        end
                        default: begin
                            n_ovalid = 1'b1;
                            n_ore    = '0;
                            n_oim    = '0;
                        end
                    endcase
                end
            end
            S_RDOUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ore    = r_rd_ok ? r_rdata[2*BIN_W-1:BIN_W] : '0;
                    n_oim    = r_rd_ok ? r_rdata[BIN_W-1:0] : '0;
                    n_state  = S_IDLE;
                end
            end
            S_SW0: begin
                raddr = r_cnt;
                if (r_cnt < rev) begin
                    n_state = S_SW1;
                end else if (r_cnt == LOG2'(POINTS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_B0;
                end else begin
                    n_cnt = r_cnt + LOG2'(1);
                end
            end
            S_SW1: begin
                raddr   = rev;
                n_state = S_SW2;
            end
            S_SW2: begin
                we      = 1'b1;
                waddr   = r_cnt;
                wdata   = r_rdata;
                n_state = S_SW3;
            end
            S_SW3: begin
                we      = 1'b1;
                waddr   = rev;
                wdata   = r_hold;
                n_cnt   = r_cnt + LOG2'(1);
                n_state = S_SW0;
            end
            S_B0: begin
                raddr   = i_b;
                n_state = S_B1;
            end
            S_B1: begin
                raddr   = i_a;
                n_state = S_M0;
            end
            S_M0: begin
                bf_ctl.mul_en  = 1'b1;
                bf_ctl.mul_sel = MUL_RR;
                n_state        = S_M1;
            end
            S_M1: begin
                bf_ctl.mul_en  = 1'b1;
                bf_ctl.mul_sel = MUL_II;
                bf_ctl.acc_ld  = 1'b1;
                n_state        = S_M2;
            end
            S_M2: begin
                bf_ctl.mul_en  = 1'b1;
                bf_ctl.mul_sel = MUL_RI;
                bf_ctl.tr_ld   = 1'b1;
                n_state        = S_M3;
            end
            S_M3: begin
                bf_ctl.mul_en  = 1'b1;
                bf_ctl.mul_sel = MUL_IR;
                bf_ctl.acc_ld  = 1'b1;
                n_state        = S_M4;
            end
            S_M4: begin
                bf_ctl.ti_ld = 1'b1;
                n_state      = S_WA;
            end
            S_WA: begin
                we      = 1'b1;
                waddr   = i_a;
                wdata   = {sum_re, sum_im};
                n_state = S_WB;
            end
            S_WB: begin
                we    = 1'b1;
                waddr = i_b;
                wdata = {dif_re, dif_im};
                if (last_bfly) begin
                    n_cnt = '0;
                    if (last_stage) begin
                        n_state = S_DONE;
                    end else begin
                        n_stage = r_stage + STG_W'(1);
                        n_state = S_B0;
                    end
                end else begin
                    n_cnt   = r_cnt + LOG2'(1);
                    n_state = S_B0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ore    = '0;
                    n_oim    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_stage  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_stage  <= n_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_rd_ok <= n_rd_ok;
        r_ore   <= n_ore;
        r_oim   <= n_oim;
        if (r_state == S_SW1) r_hold <= r_rdata;
        if (r_state == S_B0) begin
            r_w_re <= w_re;
            r_w_im <= w_im;
        end
        if (r_state == S_B1) begin
            r_x_re <= r_rdata[2*BIN_W-1:BIN_W];
            r_x_im <= r_rdata[BIN_W-1:0];
        end
        if (r_state == S_M0) begin
            r_a_re <= r_rdata[2*BIN_W-1:BIN_W];
            r_a_im <= r_rdata[BIN_W-1:0];
        end
    end

    fft_bfly u_bfly (
        .i_clk    (i_clk),
        .i_ctl    (bf_ctl),
        .i_x_re   (r_x_re),
        .i_x_im   (r_x_im),
        .i_a_re   (r_a_re),
        .i_a_im   (r_a_im),
        .i_w_re   (r_w_re),
        .i_w_im   (r_w_im),
        .o_sum_re (sum_re),
        .o_sum_im (sum_im),
        .o_dif_re (dif_re),
        .o_dif_im (dif_im)
    );

    assign o_valid    = r_ovalid;
    assign o_bin_real = r_ore;
    assign o_bin_imag = r_oim;

    `FFT_ASSERT(a_ready_idle, !o_ready || r_state == S_IDLE)
    `FFT_ASSERT(a_stage_range, r_stage <= STG_W'(LOG2 - 1))
    `FFT_ASSERT_NEXT(a_done_after_last, r_state == S_WB && last_bfly && last_stage, r_state == S_DONE)
    `FFT_ASSERT_NEXT(a_start_swaps, accept && i_req_type == REQ_START, r_state == S_SW0 && r_cnt == '0)

endmodule

// File: rtl/fft_bfly.sv
module fft_bfly (
    input  logic                                 i_clk,
    input  fft_pkg::t_bf_ctl                     i_ctl,
    input  logic signed [fft_pkg::BIN_W-1:0]     i_x_re,
    input  logic signed [fft_pkg::BIN_W-1:0]     i_x_im,
    input  logic signed [fft_pkg::BIN_W-1:0]     i_a_re,
    input  logic signed [fft_pkg::BIN_W-1:0]     i_a_im,
    input  logic signed [fft_pkg::SMP_W-1:0]     i_w_re,
    input  logic signed [fft_pkg::SMP_W-1:0]     i_w_im,
    output logic signed [fft_pkg::BIN_W-1:0]     o_sum_re,
    output logic signed [fft_pkg::BIN_W-1:0]     o_sum_im,
    output logic signed [fft_pkg::BIN_W-1:0]     o_dif_re,
    output logic signed [fft_pkg::BIN_W-1:0]     o_dif_im
);
    import fft_pkg::*;

    logic signed [BIN_W-1:0]  op_x;
    logic signed [SMP_W-1:0]  op_w;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W:0]   acc_sub;
    logic signed [PROD_W:0]   acc_add;
    logic signed [PROD_W-1:0] r_p;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [T_W-1:0]    r_tr;
    logic signed [T_W-1:0]    r_ti;

    always_comb begin
        unique case (i_ctl.mul_sel)
            MUL_RR:  begin op_x = i_x_re; op_w = i_w_re; end
            MUL_II:  begin op_x = i_x_im; op_w = i_w_im; end
            MUL_RI:  begin op_x = i_x_re; op_w = i_w_im; end
            default: begin op_x = i_x_im; op_w = i_w_re; end
        endcase
    end

    assign prod    = op_x * op_w;
    assign acc_sub = {r_acc[PROD_W-1], r_acc} - {r_p[PROD_W-1], r_p};
    assign acc_add = {r_acc[PROD_W-1], r_acc} + {r_p[PROD_W-1], r_p};

    // floor shift by 15 is a plain bit select of the signed sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) r_p <= prod;
        if (i_ctl.acc_ld) r_acc <= r_p;
        if (i_ctl.tr_ld) r_tr <= acc_sub[PROD_W:15];
        if (i_ctl.ti_ld) r_ti <= acc_add[PROD_W:15];
    end

    assign o_sum_re = f_sat({{(SUM_W-BIN_W){i_a_re[BIN_W-1]}}, i_a_re} + {r_tr[T_W-1], r_tr});
    assign o_sum_im = f_sat({{(SUM_W-BIN_W){i_a_im[BIN_W-1]}}, i_a_im} + {r_ti[T_W-1], r_ti});
    assign o_dif_re = f_sat({{(SUM_W-BIN_W){i_a_re[BIN_W-1]}}, i_a_re} - {r_tr[T_W-1], r_tr});
    assign o_dif_im = f_sat({{(SUM_W-BIN_W){i_a_im[BIN_W-1]}}, i_a_im} - {r_ti[T_W-1], r_ti});

endmodule

// File: dv/radix2_fft_in_place_tb.sv
`timescale 1ns / 1ps

module radix2_fft_in_place_tb;
    import fft_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 80000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct {
        logic signed [BIN_W-1:0] re;
        logic signed [BIN_W-1:0] im;
    } t_bin;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [1:0]              i_req_type = REQ_WRITE;
    logic [IDX_W-1:0]        i_point_index = '0;
    logic signed [SMP_W-1:0] i_sample_real = '0;
    logic signed [SMP_W-1:0] i_sample_imag = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic signed [BIN_W-1:0] o_bin_real;
    logic signed [BIN_W-1:0] o_bin_imag;

    radix2_fft_in_place DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_point_index (i_point_index),
        .i_sample_real (i_sample_real),
        .i_sample_imag (i_sample_imag),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_bin_real    (o_bin_real),
        .o_bin_imag    (o_bin_imag)
    );

    // predictor state
    int   bins_re [POINTS];
    int   bins_im [POINTS];
    int   sin_q15 [QUARTER+1];
    t_bin pending_bins [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp25(longint v);
        if (v > 64'sd16777215) return 16777215;
        if (v < -64'sd16777216) return -16777216;
        return int'(v);
    endfunction

    function automatic void build_sin_table();
        real v;
        int  r;
        for (int m = 0; m <= QUARTER; m++) begin
            v = 32768.0 * $sin(PI / 2.0 * m / QUARTER);
            r = $rtoi(v + 0.5);
            sin_q15[m] = (r > 32767) ? 32767 : r;
        end
    endfunction

    function automatic void run_fft();
        int  rev;
        int  tmp;
        int  half;
        int  k;
        int  wr;
        int  wi;
        int  ip;
        longint xr;
        longint xi;
        longint tr;
        longint ti;
        longint ar;
        longint ai;
        for (int i = 0; i < POINTS; i++) begin
            rev = 0;
            for (int b = 0; b < LOG2; b++) rev |= ((i >> b) & 1) << (LOG2 - 1 - b);
            if (i < rev) begin
                tmp = bins_re[i]; bins_re[i] = bins_re[rev]; bins_re[rev] = tmp;
                tmp = bins_im[i]; bins_im[i] = bins_im[rev]; bins_im[rev] = tmp;
            end
        end
        for (int le = 2; le <= POINTS; le <<= 1) begin
            half = le / 2;
            for (int j = 0; j < half; j++) begin
                k = j * (POINTS / le);
                if (k <= QUARTER) begin
                    wr = sin_q15[QUARTER - k];
                    wi = -sin_q15[k];
                end else begin
                    wr = -sin_q15[k - QUARTER];
                    wi = -sin_q15[2 * QUARTER - k];
                end
                for (int i = j; i < POINTS; i += le) begin
                    ip = i + half;
                    xr = bins_re[ip];
                    xi = bins_im[ip];
                    tr = (xr * wr - xi * wi) >>> 15;
                    ti = (xr * wi + xi * wr) >>> 15;
                    ar = bins_re[i];
                    ai = bins_im[i];
                    bins_re[ip] = clamp25(ar - tr);
                    bins_im[ip] = clamp25(ai - ti);
                    bins_re[i] = clamp25(ar + tr);
                    bins_im[i] = clamp25(ai + ti);
                end
            end
        end
    endfunction

    function automatic t_bin predict_bin(logic [1:0] req, int idx, int re, int im);
        t_bin r;
        r.re = '0;
        r.im = '0;
        case (req)
            REQ_WRITE: begin
                bins_re[idx] = re;
                bins_im[idx] = im;
            end
            REQ_START: run_fft();
            REQ_READ: begin
                r.re = BIN_W'(bins_re[idx]);
                r.im = BIN_W'(bins_im[idx]);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(logic [1:0] req, int idx, int re, int im);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_point_index <= IDX_W'(idx);
        i_sample_real <= SMP_W'(re);
        i_sample_imag <= SMP_W'(im);
        do @(posedge i_clk); while (!o_ready);
        pending_bins.push_back(predict_bin(req, idx, re, im));
    endtask

    function automatic int rand_sample();
        if ($urandom_range(3) == 0) return $urandom_range(0, 512) - 256;
        return int'($signed(16'($urandom)));
    endfunction

    task automatic report_mismatch(string field, logic signed [BIN_W-1:0] got,
                                   logic signed [BIN_W-1:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // result checker, watchdog
    always @(posedge i_clk) begin
        t_bin want;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (pending_bins.size() == 0) begin
                    report_mismatch("unexpected item", o_bin_real, '0);
                end else begin
                    want = pending_bins.pop_front();
                    if (o_bin_real !== want.re) report_mismatch("bin_real", o_bin_real, want.re);
                    if (o_bin_imag !== want.im) report_mismatch("bin_imag", o_bin_imag, want.im);
                end
            end
        end
    end

    // receiver backpressure with an optional long hold
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic test_directed();
        send_item(REQ_WRITE, 0, 32767, -32768);
        send_item(REQ_WRITE, POINTS - 1, -32768, 32767);
        send_item(REQ_WRITE, 1, -1, 0);
        send_item(REQ_READ, 0, 0, 0);
        send_item(REQ_READ, POINTS - 1, 0, 0);
        send_item(REQ_READ, 1, 0, 0);
        send_item(REQ_NONE, 0, 0, 0);
        send_item(REQ_NONE, POINTS - 1, -1, -1);
        send_item(REQ_WRITE, 1, 21845, -21846);
        send_item(REQ_READ, 1, 0, 0);
    endtask

    // full-scale dc drives the sums into saturation
    task automatic test_saturating_frame();
        for (int i = 0; i < POINTS; i++) send_item(REQ_WRITE, i, 32767, -32768);
        send_item(REQ_START, 0, 0, 0);
        for (int i = 0; i < 20; i++) send_item(REQ_READ, $urandom_range(POINTS - 1), 0, 0);
        send_item(REQ_READ, 0, 0, 0);
        // repeated start transforms the result again
        send_item(REQ_START, 0, 0, 0);
        for (int i = 0; i < 20; i++) send_item(REQ_READ, $urandom_range(POINTS - 1), 0, 0);
    endtask

    task automatic test_random_frame(int n_writes, int n_reads);
        for (int i = 0; i < n_writes; i++)
            send_item(REQ_WRITE, $urandom_range(POINTS - 1), rand_sample(), rand_sample());
        if ($urandom_range(7) == 0) send_item(REQ_NONE, $urandom_range(POINTS - 1), 0, 0);
        send_item(REQ_START, 0, 0, 0);
        for (int i = 0; i < n_reads; i++) send_item(REQ_READ, $urandom_range(POINTS - 1), 0, 0);
    endtask

    task automatic test_receiver_hold();
        hold_req++;
        for (int i = 0; i < 24; i++) send_item(REQ_READ, $urandom_range(POINTS - 1), 0, 0);
    endtask

    initial begin
        build_sin_table();
        for (int i = 0; i < POINTS; i++) begin
            bins_re[i] = 0;
            bins_im[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturating_frame();
        tx_idle_pct = 51;
        test_random_frame(120, 60);
        tx_idle_pct = 0;
        rx_stall_pct = 51;
        test_random_frame(120, 60);
        test_receiver_hold();
        tx_idle_pct = 28;
        rx_stall_pct = 28;
        test_random_frame(120, 60);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        test_random_frame(120, 60);
        tx_idle_pct = 51;
        test_random_frame(110, 60);
        tx_idle_pct = 28;
        rx_stall_pct = 28;
        test_random_frame(110, 60);

        i_valid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
